FILE: rtl/core/bts_pkg.sv
// -----------------------------------------------------------------------------
// Blob target selector package
// Box type, lane control group, result status codes and register indexes.
// -----------------------------------------------------------------------------
package bts_pkg;

   localparam int unsigned COORD_W  = 8;
   localparam int unsigned HUE_W    = 3;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DAT_W = 8;

   localparam logic [COORD_W-1:0] MIN_SIZE_RESET = 8'd30;

   typedef struct packed {
      logic [COORD_W-1:0] bottom;
      logic [COORD_W-1:0] right;
      logic [COORD_W-1:0] top;
      logic [COORD_W-1:0] left;
   } box_type;

   typedef struct packed {
      logic hit;
      logic clear;
   } lane_ctl_type;

   typedef enum logic [2:0] {
      STATUS_EMPTY         = 3'd0,
      STATUS_TALL          = 3'd1,
      STATUS_CLUSTER_OK    = 3'd2,
      STATUS_CLUSTER_SMALL = 3'd3,
      STATUS_COLOR_ABSENT  = 3'd4
   } status_type;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SIZE         = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_USE_TARGET_COLOR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_COLOR     = 2'd2;

endpackage

FILE: rtl/core/blob_target_selector.sv
// -----------------------------------------------------------------------------
// Blob target selector
// Picks one target per frame of colour blobs: the first tallest blob that
// reaches min_size, else the union box of one colour.
// -----------------------------------------------------------------------------
// The result beat is registered: a frame_last beat passes the input register,
// then the result register.
// Throughput: one blob beat per cycle, set by the single-pass update of the
// per-colour union box lanes; a frame_last beat waits only while a held
// result is stalled.
// Reset: synchronous; valid flags and settings return to defaults and frame state clears.
module blob_target_selector
   import bts_pkg::*;
#(
   parameter int unsigned NUM_COLORS = 8
)
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_blob_valid,
   input  logic [COORD_W-1:0]   req_left_x,
   input  logic [COORD_W-1:0]   req_top_y,
   input  logic [COORD_W-1:0]   req_right_x,
   input  logic [COORD_W-1:0]   req_bottom_y,
   input  logic [HUE_W-1:0]     req_blob_hue,
   input  logic                 req_frame_last,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_status,
   output logic [COORD_W-1:0]   rsp_out_left_x,
   output logic [COORD_W-1:0]   rsp_out_top_y,
   output logic [COORD_W-1:0]   rsp_out_right_x,
   output logic [COORD_W-1:0]   rsp_out_bottom_y,
   output logic [HUE_W-1:0]     rsp_out_hue
);

   localparam int unsigned IDX_W = (NUM_COLORS > 1) ? $clog2(NUM_COLORS) : 1;

   typedef struct packed {
      logic               blob_valid;
      box_type            box;
      logic [HUE_W-1:0]   hue;
      logic               frame_last;
   } beat_type;

   typedef struct packed {
      status_type         status;
      box_type            box;
      logic [HUE_W-1:0]   hue;
   } result_type;

   // configuration
   logic [COORD_W-1:0] min_size_ff;
   logic               use_target_color_ff;
   logic [HUE_W-1:0]   target_color_ff;

   // input register
   logic     s1_valid_ff;
   beat_type s1_ff;
   logic     s1_go;
   logic     out_free;
   logic     req_take;

   // frame state
   logic               tall_found_ff, tall_found_in;
   logic [COORD_W-1:0] tall_height_ff, tall_height_in;
   box_type            tall_box_ff, tall_box_in;
   logic [HUE_W-1:0]   tall_hue_ff, tall_hue_in;
   logic               top_seen_ff, top_seen_in;
   logic [COORD_W-1:0] top_height_ff, top_height_in;
   logic [HUE_W-1:0]   top_hue_ff, top_hue_in;

   logic [COORD_W-1:0] blob_height;
   logic               blob_go;
   logic               frame_end;

   lane_ctl_type       lane_ctl [NUM_COLORS];
   logic               lane_seen_in [NUM_COLORS];
   box_type            lane_box_in [NUM_COLORS];

   // result
   logic               rsp_valid_ff;
   result_type         rsp_ff, rsp_in;
   logic [HUE_W-1:0]   pick_hue;
   logic [7:0]         pick_wide;
   logic [IDX_W-1:0]   pick_idx;
   logic               pick_ok;
   box_type            pick_box;
   logic [COORD_W-1:0] union_w, union_h;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         min_size_ff         <= MIN_SIZE_RESET;
         use_target_color_ff <= 1'b0;
         target_color_ff     <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MIN_SIZE:         min_size_ff         <= csr_wdata;
            CSR_USE_TARGET_COLOR: use_target_color_ff <= csr_wdata[0];
            CSR_TARGET_COLOR:     target_color_ff     <= csr_wdata[HUE_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------ handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_go     = s1_valid_ff && (!s1_ff.frame_last || out_free);
   assign req_stall = s1_valid_ff && !s1_go;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_ff.blob_valid <= req_blob_valid;
         s1_ff.box.left   <= req_left_x;
         s1_ff.box.top    <= req_top_y;
         s1_ff.box.right  <= req_right_x;
         s1_ff.box.bottom <= req_bottom_y;
         s1_ff.hue        <= req_blob_hue;
         s1_ff.frame_last <= req_frame_last;
      end
   end

   // ---------------------------------------------------------- frame state
   assign blob_go     = s1_go && s1_ff.blob_valid;
   assign frame_end   = s1_go && s1_ff.frame_last;
   assign blob_height = s1_ff.box.bottom - s1_ff.box.top + 8'd1;

   always_comb begin
      tall_found_in  = tall_found_ff;
      tall_height_in = tall_height_ff;
      tall_box_in    = tall_box_ff;
      tall_hue_in    = tall_hue_ff;
      top_seen_in    = top_seen_ff;
      top_height_in  = top_height_ff;
      top_hue_in     = top_hue_ff;
      // a zero height never beats the cleared tall height
      if (blob_go && blob_height >= min_size_ff && blob_height > tall_height_ff) begin
         tall_found_in  = 1'b1;
         tall_height_in = blob_height;
         tall_box_in    = s1_ff.box;
         tall_hue_in    = s1_ff.hue;
      end
      if (blob_go && (!top_seen_ff || blob_height > top_height_ff)) begin
         top_seen_in   = 1'b1;
         top_height_in = blob_height;
         top_hue_in    = s1_ff.hue;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || frame_end) begin
         tall_found_ff  <= 1'b0;
         tall_height_ff <= '0;
         tall_box_ff    <= '0;
         tall_hue_ff    <= '0;
         top_seen_ff    <= 1'b0;
         top_height_ff  <= '0;
         top_hue_ff     <= '0;
      end else begin
         tall_found_ff  <= tall_found_in;
         tall_height_ff <= tall_height_in;
         tall_box_ff    <= tall_box_in;
         tall_hue_ff    <= tall_hue_in;
         top_seen_ff    <= top_seen_in;
         top_height_ff  <= top_height_in;
         top_hue_ff     <= top_hue_in;
      end
   end

   for (genvar i = 0; i < NUM_COLORS; i++) begin : g_lane
      assign lane_ctl[i].hit   = blob_go && (8'(s1_ff.hue) == 8'(i));
      assign lane_ctl[i].clear = frame_end;

      bts_hue_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctl      (lane_ctl[i]),
         .blob_box (s1_ff.box),
         .seen_in  (lane_seen_in[i]),
         .box_in   (lane_box_in[i])
      );
   end

   // --------------------------------------------------------------- result
   assign pick_hue  = use_target_color_ff ? target_color_ff : top_hue_in;
   assign pick_wide = 8'(pick_hue);
   assign pick_idx  = pick_wide[IDX_W-1:0];
   assign pick_ok   = (pick_wide < 8'(NUM_COLORS)) && lane_seen_in[pick_idx];
   assign pick_box  = lane_box_in[pick_idx];
   assign union_w   = pick_box.right  - pick_box.left + 8'd1;
   assign union_h   = pick_box.bottom - pick_box.top  + 8'd1;

   always_comb begin
      rsp_in.status = STATUS_EMPTY;
      rsp_in.box    = '0;
      rsp_in.hue    = '0;
      priority if (tall_found_in) begin
         rsp_in.status = STATUS_TALL;
         rsp_in.box    = tall_box_in;
         rsp_in.hue    = tall_hue_in;
      end else if (top_seen_in && pick_ok) begin
         rsp_in.status = (union_w < min_size_ff || union_h < min_size_ff) ?
                         STATUS_CLUSTER_SMALL : STATUS_CLUSTER_OK;
         rsp_in.box    = pick_box;
         rsp_in.hue    = pick_hue;
      end else if (top_seen_in) begin
         rsp_in.status = STATUS_COLOR_ABSENT;
         rsp_in.hue    = pick_hue;
      end else begin
         rsp_in.status = STATUS_EMPTY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (frame_end) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // hold the payload until the beat is taken
   always_ff @(posedge clock) begin
      if (frame_end) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_out_left_x   = rsp_ff.box.left;
   assign rsp_out_top_y    = rsp_ff.box.top;
   assign rsp_out_right_x  = rsp_ff.box.right;
   assign rsp_out_bottom_y = rsp_ff.box.bottom;
   assign rsp_out_hue      = rsp_ff.hue;

   // ----------------------------------------------------------- assertions
   a_frame_end_gives_result: assert property (@(posedge clock) disable iff (reset)
      frame_end |=> rsp_valid_ff)
      else $error("frame end did not raise a result beat");

   a_frame_end_clears: assert property (@(posedge clock) disable iff (reset)
      frame_end |=> (!top_seen_ff && !tall_found_ff && tall_height_ff == '0))
      else $error("frame state not cleared after frame end");

   a_tall_implies_seen: assert property (@(posedge clock) disable iff (reset)
      tall_found_ff |-> (top_seen_ff && tall_height_ff != '0 &&
                         top_height_ff >= tall_height_ff))
      else $error("tall blob recorded without a consistent tallest blob");

   a_stall_only_on_last: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s1_ff.frame_last && rsp_valid_ff && rsp_stall))
      else $error("input stalled without a blocked frame end");

endmodule

FILE: rtl/core/bts_hue_lane.sv
// -----------------------------------------------------------------------------
// Blob target selector colour lane
// Holds the union box of one colour for the current frame and offers its
// next value in the same cycle.
// -----------------------------------------------------------------------------
module bts_hue_lane
   import bts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  lane_ctl_type ctl,
   input  box_type      blob_box,
   output logic         seen_in,
   output box_type      box_in
);

   logic    seen_ff;
   box_type box_ff;

   always_comb begin
      seen_in = seen_ff | ctl.hit;
      box_in  = box_ff;
      if (ctl.hit && !seen_ff) begin
         box_in = blob_box;
      end else if (ctl.hit) begin
         box_in.left   = (blob_box.left   < box_ff.left)   ? blob_box.left   : box_ff.left;
         box_in.top    = (blob_box.top    < box_ff.top)    ? blob_box.top    : box_ff.top;
         box_in.right  = (blob_box.right  > box_ff.right)  ? blob_box.right  : box_ff.right;
         box_in.bottom = (blob_box.bottom > box_ff.bottom) ? blob_box.bottom : box_ff.bottom;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else begin
         seen_ff <= ctl.clear ? 1'b0 : seen_in;
      end
   end

   // box is only read while seen is set
   always_ff @(posedge clock) begin
      box_ff <= box_in;
   end

endmodule

FILE: sim/tb_blob_target_selector.sv
// -----------------------------------------------------------------------------
// Blob target selector testbench
// Drives frames of colour blobs through the request channel, predicts the
// target that each frame's last beat yields and checks every result beat
// field by field. Register settings change between phases while idle.
// -----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_blob_target_selector
   import bts_pkg::*;
();

   localparam int HUES       = 8;
   localparam int ITEM_GOAL  = 1950;
   localparam int PHASES     = 12;
   localparam int DRAIN_WAIT = 6;
   localparam int SHOW_MAX   = 50;

   typedef struct packed {
      logic               valid;
      logic [COORD_W-1:0] left;
      logic [COORD_W-1:0] top;
      logic [COORD_W-1:0] right;
      logic [COORD_W-1:0] bottom;
      logic [HUE_W-1:0]   hue;
      logic               last;
   } blob_type;

   typedef struct packed {
      status_type       status;
      box_type          box;
      logic [HUE_W-1:0] hue;
   } target_type;

   logic                 clock;
   logic                 reset     = 1'b1;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_MIN_SIZE;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_blob_valid = 1'b0;
   logic [COORD_W-1:0]   req_left_x     = '0;
   logic [COORD_W-1:0]   req_top_y      = '0;
   logic [COORD_W-1:0]   req_right_x    = '0;
   logic [COORD_W-1:0]   req_bottom_y   = '0;
   logic [HUE_W-1:0]     req_blob_hue   = '0;
   logic                 req_frame_last = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [2:0]           rsp_status;
   logic [COORD_W-1:0]   rsp_out_left_x;
   logic [COORD_W-1:0]   rsp_out_top_y;
   logic [COORD_W-1:0]   rsp_out_right_x;
   logic [COORD_W-1:0]   rsp_out_bottom_y;
   logic [HUE_W-1:0]     rsp_out_hue;

   blob_type   blob_q[$];
   target_type target_q[$];
   logic       req_beat = 1'b0;
   int         cycle_cnt = 0;
   int         err_cnt = 0;
   int         fed_cnt = 0;

   // register copies
   logic [7:0]       cfg_min = MIN_SIZE_RESET;
   logic             cfg_use = 1'b0;
   logic [HUE_W-1:0] cfg_hue = '0;

   // frame state
   logic             best_found;
   logic [7:0]       best_h;
   box_type          best_box;
   logic [HUE_W-1:0] best_hue;
   logic             lead_seen;
   logic [7:0]       lead_h;
   logic [HUE_W-1:0] lead_hue;
   logic             hue_hit[HUES];
   box_type          hue_span[HUES];

   // quiet window: no idling on either side
   wire calm = (cycle_cnt % 2048) >= 1536;

   blob_target_selector dut (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("** blob_target_selector: FAILED **");
      $finish;
   end

   function automatic bit want_gap();
      return !calm && ($urandom_range(0, 99) < 29);
   endfunction

   function automatic void clear_frame();
      best_found = 1'b0;
      best_h     = '0;
      best_box   = '0;
      best_hue   = '0;
      lead_seen  = 1'b0;
      lead_h     = '0;
      lead_hue   = '0;
      for (int i = 0; i < HUES; i++) begin
         hue_hit[i]  = 1'b0;
         hue_span[i] = '0;
      end
   endfunction

   // advance the frame state by one accepted beat; on the last beat queue the target
   function automatic void track_blob(blob_type bt);
      logic [7:0]       h, w, uh;
      logic [HUE_W-1:0] col;
      box_type          bx, ub;
      target_type       tgt;
      bx.left   = bt.left;
      bx.top    = bt.top;
      bx.right  = bt.right;
      bx.bottom = bt.bottom;
      if (bt.valid) begin
         h = bt.bottom - bt.top + 8'd1;
         if (h >= cfg_min && h > best_h) begin
            best_found = 1'b1;
            best_h     = h;
            best_box   = bx;
            best_hue   = bt.hue;
         end
         if (!lead_seen || h > lead_h) begin
            lead_seen = 1'b1;
            lead_h    = h;
            lead_hue  = bt.hue;
         end
         if (!hue_hit[bt.hue]) begin
            hue_hit[bt.hue]  = 1'b1;
            hue_span[bt.hue] = bx;
         end else begin
            ub = hue_span[bt.hue];
            if (bt.left < ub.left)     ub.left   = bt.left;
            if (bt.top < ub.top)       ub.top    = bt.top;
            if (bt.right > ub.right)   ub.right  = bt.right;
            if (bt.bottom > ub.bottom) ub.bottom = bt.bottom;
            hue_span[bt.hue] = ub;
         end
      end
      if (bt.last) begin
         tgt.status = STATUS_EMPTY;
         tgt.box    = '0;
         tgt.hue    = '0;
         if (best_found) begin
            tgt.status = STATUS_TALL;
            tgt.box    = best_box;
            tgt.hue    = best_hue;
         end else if (lead_seen) begin
            col     = cfg_use ? cfg_hue : lead_hue;
            tgt.hue = col;
            if (hue_hit[col]) begin
               ub = hue_span[col];
               w  = ub.right - ub.left + 8'd1;
               uh = ub.bottom - ub.top + 8'd1;
               tgt.status = (w < cfg_min || uh < cfg_min) ? STATUS_CLUSTER_SMALL
                                                          : STATUS_CLUSTER_OK;
               tgt.box = ub;
            end else begin
               tgt.status = STATUS_COLOR_ABSENT;
            end
         end
         target_q.push_back(tgt);
         clear_frame();
      end
   endfunction

   task automatic report_error(string msg);
      err_cnt++;
      if (err_cnt <= SHOW_MAX) $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) report_error($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   // accept request beats, check result beats
   always @(posedge clock) begin
      target_type want;
      if (reset) begin
         req_beat <= 1'b0;
      end else begin
         cycle_cnt <= cycle_cnt + 1;
         req_beat  <= req_valid && !req_stall;
         if (req_valid && !req_stall)
            track_blob('{req_blob_valid, req_left_x, req_top_y, req_right_x,
                         req_bottom_y, req_blob_hue, req_frame_last});
         if (rsp_valid && !rsp_stall) begin
            if (target_q.size() == 0) begin
               report_error($sformatf("result beat with none expected, status %0d",
                                      rsp_status));
            end else begin
               want = target_q.pop_front();
               check_field("status", 8'(rsp_status), 8'(want.status));
               check_field("left_x", rsp_out_left_x, want.box.left);
               check_field("top_y", rsp_out_top_y, want.box.top);
               check_field("right_x", rsp_out_right_x, want.box.right);
               check_field("bottom_y", rsp_out_bottom_y, want.box.bottom);
               check_field("hue", 8'(rsp_out_hue), 8'(want.hue));
            end
         end
      end
   end

   // request driver: hold a stalled beat, else take the next pending blob or idle
   always @(negedge clock) begin
      blob_type bt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_beat) begin
         if (blob_q.size() != 0 && !want_gap()) begin
            bt = blob_q.pop_front();
            req_valid      <= 1'b1;
            req_blob_valid <= bt.valid;
            req_left_x     <= bt.left;
            req_top_y      <= bt.top;
            req_right_x    <= bt.right;
            req_bottom_y   <= bt.bottom;
            req_blob_hue   <= bt.hue;
            req_frame_last <= bt.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else       rsp_stall <= want_gap();
   end

   task automatic push_blob(logic v, logic [7:0] l, logic [7:0] t, logic [7:0] r,
                            logic [7:0] b, logic [HUE_W-1:0] hue, logic last);
      blob_q.push_back('{v, l, t, r, b, hue, last});
      if (v || last) fed_cnt++;
   endtask

   // beat of random junk that carries no blob
   task automatic push_noise(logic last);
      push_blob(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                3'($urandom_range(0, 7)), last);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // upper bits of the narrow registers carry junk that must be dropped
   task automatic set_config(logic [7:0] min_sz, logic use_tc, logic [HUE_W-1:0] tc);
      logic [7:0] junk;
      junk = 8'($urandom_range(0, 255));
      write_reg(CSR_MIN_SIZE, min_sz);
      write_reg(CSR_USE_TARGET_COLOR, {junk[7:1], use_tc});
      write_reg(CSR_TARGET_COLOR, {junk[7:3], tc});
      cfg_min = min_sz;
      cfg_use = use_tc;
      cfg_hue = tc;
   endtask

   task automatic drain();
      while (blob_q.size() != 0 || req_valid || target_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic queue_frame();
      int               n, mode;
      logic [7:0]       l, t, r, b, h, hi;
      logic [HUE_W-1:0] hue_a, hue_b, hue;
      n     = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
      hue_a = 3'($urandom_range(0, HUES - 1));
      hue_b = 3'($urandom_range(0, HUES - 1));
      if (n == 0) begin
         push_noise(1'b1);
         return;
      end
      for (int i = 0; i < n; i++) begin
         // noise beat that carries no blob
         if ($urandom_range(0, 19) == 0)
            push_noise(1'b0);
         mode = $urandom_range(0, 99);
         hi   = (cfg_min > 8'd1) ? cfg_min - 8'd1 : 8'd1;
         t    = 8'($urandom_range(0, 255));
         l    = 8'($urandom_range(0, 255));
         if (mode < 45)      h = 8'($urandom_range(1, hi));
         else if (mode < 65) h = cfg_min + 8'($urandom_range(0, 2)) - 8'd1;
         else if (mode < 80) h = 8'($urandom_range(0, 255));
         else                h = 8'd0;
         b = t + h - 8'd1;
         r = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                         : l + 8'($urandom_range(0, 60));
         if (mode >= 90) begin
            l = {8{$urandom_range(0, 1) == 1}};
            t = {8{$urandom_range(0, 1) == 1}};
            r = {8{$urandom_range(0, 1) == 1}};
            b = {8{$urandom_range(0, 1) == 1}};
         end
         case ($urandom_range(0, 9))
            0, 1, 2: hue = 3'($urandom_range(0, HUES - 1));
            3, 4, 5: hue = hue_b;
            default: hue = hue_a;
         endcase
         if (i == n - 1 && $urandom_range(0, 9) == 0) begin
            push_blob(1'b1, l, t, r, b, hue, 1'b0);
            push_noise(1'b1);
         end else begin
            push_blob(1'b1, l, t, r, b, hue, i == n - 1);
         end
      end
   endtask

   initial begin
      int         goal;
      logic [7:0] min_sz;
      clear_frame();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: min_size 30, tallest blob's colour
      push_blob(1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 3'd0, 1'b1);          // empty frame
      push_blob(1'b1, 8'd10, 8'd10, 8'd20, 8'd50, 3'd3, 1'b1);      // one tall blob
      push_blob(1'b1, 8'd1, 8'd2, 8'd3, 8'd41, 3'd1, 1'b0);         // tie: first wins
      push_blob(1'b1, 8'd5, 8'd6, 8'd7, 8'd45, 3'd2, 1'b1);
      push_blob(1'b1, 8'd0, 8'd0, 8'd5, 8'd39, 3'd4, 1'b0);         // taller later wins
      push_blob(1'b1, 8'd9, 8'd9, 8'd9, 8'd99, 3'd5, 1'b1);
      push_blob(1'b1, 8'd0, 8'd0, 8'd255, 8'd255, 3'd6, 1'b0);      // height wraps to zero
      push_blob(1'b0, 8'd255, 8'd255, 8'd255, 8'd255, 3'd7, 1'b0);  // ignored beat
      push_blob(1'b1, 8'd20, 8'd20, 8'd25, 8'd25, 3'd6, 1'b1);
      push_blob(1'b1, 8'd0, 8'd0, 8'd10, 8'd10, 3'd5, 1'b0);        // merge to a good cluster
      push_blob(1'b1, 8'd40, 8'd40, 8'd50, 8'd50, 3'd5, 1'b0);
      push_blob(1'b1, 8'd100, 8'd100, 8'd101, 8'd101, 3'd2, 1'b1);
      push_blob(1'b1, 8'd200, 8'd200, 8'd10, 8'd10, 3'd7, 1'b1);    // inverted, wraps tall
      push_blob(1'b1, 8'd250, 8'd5, 8'd3, 8'd20, 3'd0, 1'b0);       // inverted merge
      push_blob(1'b1, 8'd2, 8'd1, 8'd4, 8'd6, 3'd0, 1'b1);
      push_blob(1'b1, 8'd255, 8'd255, 8'd255, 8'd255, 3'd7, 1'b1);
      drain();

      // zero threshold still never takes a zero-height blob; colour absent
      set_config(8'd0, 1'b1, 3'd7);
      push_blob(1'b1, 8'd3, 8'd10, 8'd9, 8'd9, 3'd2, 1'b1);
      push_blob(1'b1, 8'd1, 8'd1, 8'd1, 8'd1, 3'd7, 1'b1);
      drain();

      set_config(8'd255, 1'b1, 3'd3);
      push_blob(1'b1, 8'd0, 8'd0, 8'd9, 8'd254, 3'd1, 1'b1);
      push_blob(1'b1, 8'd0, 8'd0, 8'd254, 8'd253, 3'd3, 1'b0);
      push_blob(1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 3'd3, 1'b1);
      drain();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       min_sz = 8'd0;
            1:       min_sz = 8'd255;
            2:       min_sz = MIN_SIZE_RESET;
            default: min_sz = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                          : 8'($urandom_range(8, 60));
         endcase
         set_config(min_sz, p[0] ^ ($urandom_range(0, 3) == 0),
                    p[2:0] ^ 3'($urandom_range(0, 7)));
         goal = ITEM_GOAL * (p + 1) / PHASES;
         while (fed_cnt < goal) queue_frame();
         drain();
      end

      if (err_cnt == 0) begin
         $display("** blob_target_selector: PASSED **");
      end else begin
         $display("** blob_target_selector: FAILED **");
      end
      $finish;
   end

endmodule

FILE: blob_target_selector.f
rtl/core/bts_pkg.sv
rtl/core/bts_hue_lane.sv
rtl/core/blob_target_selector.sv
sim/tb_blob_target_selector.sv
